>>> hdl/qrm_pkg.sv
// Shared widths, constants and types of the quaternion to rotation matrix core.
package qrm_pkg;

    localparam int QW      = 16;          // quaternion component width
    localparam int PW      = 32;          // product of two components
    localparam int NW      = 35;          // signed numerator width
    localparam int SW      = 33;          // unsigned squared norm width
    localparam int MAGW    = 34;          // numerator magnitude width
    localparam int FRAC    = 14;          // fraction bits of Q1.14
    localparam int QBITS   = 16;          // quotient bits developed
    localparam int REMW    = MAGW + FRAC + 1;
    localparam int DIV_LAT = QBITS + 1;   // register stages in one lane
    localparam int NLANE   = 9;
    localparam int CHW     = 8;
    localparam int THRW    = 32;

    localparam logic [THRW-1:0]    THR_RESET = 32'd1;
    localparam logic signed [QW-1:0] ONE_Q14 = 16'sd16384;

    typedef logic signed [NW-1:0] num_t;
    typedef logic [SW-1:0]        norm_t;
    typedef logic signed [QW-1:0] entry_t;

    // Control that travels beside the numeric lanes.
    typedef struct packed {
        logic           valid;
        logic [CHW-1:0] channel;
        logic           degen;
    } side_t;

endpackage

>>> hdl/qrm_in_if.sv
// Input channel carrying a channel number and one quaternion.
interface qrm_in_if;
    logic               valid;
    logic               ready;
    logic [7:0]         channel;
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;

    modport source (output valid, channel, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, channel, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

>>> hdl/qrm_out_if.sv
// Output channel carrying the nine matrix entries and the degenerate flag.
interface qrm_out_if;
    logic               valid;
    logic               ready;
    logic [7:0]         channel_out;
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
    logic               degenerate;

    modport source (output valid, channel_out, m00, m01, m02, m10, m11, m12,
                    m20, m21, m22, degenerate, input ready);
    modport sink   (input valid, channel_out, m00, m01, m02, m10, m11, m12,
                    m20, m21, m22, degenerate, output ready);
endinterface

>>> hdl/qrm_front.sv
// Product and numerator stages: squared norm, nine numerators, degenerate test.
module qrm_front
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [qrm_pkg::CHW-1:0]     in_channel,
    input  logic signed [qrm_pkg::QW-1:0] w,
    input  logic signed [qrm_pkg::QW-1:0] x,
    input  logic signed [qrm_pkg::QW-1:0] y,
    input  logic signed [qrm_pkg::QW-1:0] z,
    input  logic [qrm_pkg::THRW-1:0]    thr,
    output qrm_pkg::side_t              side,
    output qrm_pkg::norm_t              norm,
    output qrm_pkg::num_t               num [qrm_pkg::NLANE]
);
    import qrm_pkg::*;

    logic signed [PW-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [PW-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic                 va_reg;
    logic [CHW-1:0]       cha_reg;

    num_t  s_sum;
    num_t  num_next [NLANE];
    num_t  num_reg  [NLANE];
    norm_t s_reg;
    side_t side_reg, side_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            side_reg <= '0;
        end
        else if (en)
        begin
            va_reg   <= in_valid;
            side_reg <= side_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cha_reg <= in_channel;
            ww_reg  <= w * w;
            xx_reg  <= x * x;
            yy_reg  <= y * y;
            zz_reg  <= z * z;
            xy_reg  <= x * y;
            xz_reg  <= x * z;
            yz_reg  <= y * z;
            wx_reg  <= w * x;
            wy_reg  <= w * y;
            wz_reg  <= w * z;
            s_reg   <= s_sum[SW-1:0];
            for (int k = 0; k < NLANE; k++)
            begin
                num_reg[k] <= num_next[k];
            end
        end
    end

    always_comb
    begin
        s_sum = NW'(ww_reg) + NW'(xx_reg) + NW'(yy_reg) + NW'(zz_reg);
        num_next[0] = s_sum - ((NW'(yy_reg) + NW'(zz_reg)) <<< 1);
        num_next[1] = (NW'(xy_reg) - NW'(wz_reg)) <<< 1;
        num_next[2] = (NW'(xz_reg) + NW'(wy_reg)) <<< 1;
        num_next[3] = (NW'(xy_reg) + NW'(wz_reg)) <<< 1;
        num_next[4] = s_sum - ((NW'(xx_reg) + NW'(zz_reg)) <<< 1);
        num_next[5] = (NW'(yz_reg) - NW'(wx_reg)) <<< 1;
        num_next[6] = (NW'(xz_reg) - NW'(wy_reg)) <<< 1;
        num_next[7] = (NW'(yz_reg) + NW'(wx_reg)) <<< 1;
        num_next[8] = s_sum - ((NW'(xx_reg) + NW'(yy_reg)) <<< 1);
        side_next.valid   = va_reg;
        side_next.channel = cha_reg;
        side_next.degen   = (s_sum == '0) || (s_sum[SW-1:0] < SW'(thr));
    end

    assign side = side_reg;
    assign norm = s_reg;
    assign num  = num_reg;

endmodule

>>> hdl/qrm_div_lane.sv
// One lane: rounded, saturated num * 2^14 / norm by a pipelined restoring divider.
module qrm_div_lane
(
    input  logic             clk,
    input  logic             en,
    input  qrm_pkg::num_t    num,
    input  qrm_pkg::norm_t   norm,
    output qrm_pkg::entry_t  q
);
    import qrm_pkg::*;

    logic [REMW-1:0]  rem_reg [QBITS];
    norm_t            s_reg   [QBITS];
    logic [QBITS-1:0] q_reg   [QBITS+1];
    logic             neg_reg [QBITS+1];
    logic             ovf_reg [QBITS+1];

    logic [NW-1:0]    mag_full;
    logic [REMW-1:0]  dividend;
    logic [QW-1:0]    qmag;

    always_comb
    begin
        mag_full = num[NW-1] ? NW'(-num) : NW'(num);
        dividend = (REMW'(mag_full[MAGW-1:0]) << FRAC) + REMW'(norm >> 1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= dividend;
            s_reg[0]   <= norm;
            q_reg[0]   <= '0;
            neg_reg[0] <= num[NW-1];
            ovf_reg[0] <= dividend >= (REMW'(norm) << QBITS);
        end
    end

    // Stage k decides quotient bit QBITS-k.
    for (genvar k = 1; k <= QBITS; k++)
    begin : g_stage
        localparam int B = QBITS - k;
        logic [REMW-1:0] trial;
        logic            ge;

        always_comb
        begin
            trial = REMW'(s_reg[k-1]) << B;
            ge    = rem_reg[k-1] >= trial;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k]   <= q_reg[k-1] | (QBITS'(ge) << B);
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end

        if (k < QBITS)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k] <= ge ? rem_reg[k-1] - trial : rem_reg[k-1];
                    s_reg[k]   <= s_reg[k-1];
                end
            end
        end
    end

    always_comb
    begin
        if (ovf_reg[QBITS] || (q_reg[QBITS] > QBITS'(ONE_Q14)))
        begin
            qmag = ONE_Q14;
        end
        else
        begin
            qmag = QW'(q_reg[QBITS]);
        end
        q = neg_reg[QBITS] ? entry_t'(-qmag) : entry_t'(qmag);
    end

endmodule

>>> hdl/quaternion_to_rotation_matrix_core.sv
// Quaternion to 3x3 rotation matrix core: front stages, nine divider lanes, merge.
// An accepted input transaction passes one product stage, one numerator stage,
// 17 divider stages and the output register before it becomes an output transaction.
// Throughput is one transaction per cycle; the whole pipeline holds only when the
// output register is full and not being taken. The 17-stage restoring divider in
// each lane sets the latency. Reset clears all valid flags and sets the threshold to 1.
module quaternion_to_rotation_matrix_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    qrm_in_if.sink                        quat_in,
    qrm_out_if.source                     mat_out,
    input  logic                          cfg_we,
    input  logic [qrm_pkg::THRW-1:0]      cfg_wdata
);
    import qrm_pkg::*;

    // Threshold on the squared norm, in Q4.28 units.
    logic [THRW-1:0] thr_reg;

    // Global advance: every stage moves when the output register can take data.
    logic en;

    side_t  front_side;
    norm_t  front_norm;
    num_t   front_num [NLANE];
    entry_t lane_q    [NLANE];

    // Control delay line matching the divider lanes.
    side_t  side_reg  [DIV_LAT];

    // Output register: the merge of the lanes with the identity fallback.
    logic           out_valid_reg;
    logic [CHW-1:0] out_channel_reg;
    logic           out_degen_reg;
    entry_t         out_m_reg  [NLANE];
    entry_t         out_m_next [NLANE];

    assign en            = !out_valid_reg || mat_out.ready;
    assign quat_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_we)
        begin
            thr_reg <= cfg_wdata;
        end
    end

    qrm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_valid   (quat_in.valid),
        .in_channel (quat_in.channel),
        .w          (quat_in.quat_w),
        .x          (quat_in.quat_x),
        .y          (quat_in.quat_y),
        .z          (quat_in.quat_z),
        .thr        (thr_reg),
        .side       (front_side),
        .norm       (front_norm),
        .num        (front_num)
    );

    // One divider lane per matrix entry, all sharing the same norm.
    for (genvar k = 0; k < NLANE; k++)
    begin : g_lane
        qrm_div_lane u_lane
        (
            .clk  (clk),
            .en   (en),
            .num  (front_num[k]),
            .norm (front_norm),
            .q    (lane_q[k])
        );
    end

    // The control delay line is cleared as a whole so that no valid flag survives reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                side_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            side_reg[0] <= front_side;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
            out_valid_reg <= side_reg[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_channel_reg <= side_reg[DIV_LAT-1].channel;
            out_degen_reg   <= side_reg[DIV_LAT-1].degen;
            out_m_reg       <= out_m_next;
        end
    end

    // Merge: a degenerate norm replaces the lane results with the identity matrix.
    always_comb
    begin
        for (int k = 0; k < NLANE; k++)
        begin
            if (side_reg[DIV_LAT-1].degen)
            begin
                out_m_next[k] = ((k % 4) == 0) ? ONE_Q14 : '0;
            end
            else
            begin
                out_m_next[k] = lane_q[k];
            end
        end
    end

    assign mat_out.valid       = out_valid_reg;
    assign mat_out.channel_out = out_channel_reg;
    assign mat_out.degenerate  = out_degen_reg;
    assign mat_out.m00         = out_m_reg[0];
    assign mat_out.m01         = out_m_reg[1];
    assign mat_out.m02         = out_m_reg[2];
    assign mat_out.m10         = out_m_reg[3];
    assign mat_out.m11         = out_m_reg[4];
    assign mat_out.m12         = out_m_reg[5];
    assign mat_out.m20         = out_m_reg[6];
    assign mat_out.m21         = out_m_reg[7];
    assign mat_out.m22         = out_m_reg[8];

endmodule
